### hdl/i2c_eeprom_byte_access_master_unit_defines.svh
// assertion macros shared by the bus master modules
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_UNIT_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is asserted
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/i2cm_pkg.sv
// shared types and constants of the two-wire eeprom bus master
package i2cm_pkg;

  // command codes carried with a tick
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEVICE_ADDRESS    = 3'd0,
    CFG_BIT_HALF_TICKS    = 3'd1,
    CFG_START_STOP_TICKS  = 3'd2,
    CFG_ACK_TIMEOUT_POLLS = 3'd3,
    CFG_WRITE_WAIT_TICKS  = 3'd4
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [6:0]  RST_DEVICE_ADDRESS    = 7'd80;
  localparam logic [7:0]  RST_BIT_HALF_TICKS    = 8'd2;
  localparam logic [7:0]  RST_START_STOP_TICKS  = 8'd4;
  localparam logic [7:0]  RST_ACK_TIMEOUT_POLLS = 8'd250;
  localparam logic [15:0] RST_WRITE_WAIT_TICKS  = 16'd5000;

  // bits per transferred byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_S_SETUP = 4'd1,
    PH_S_HOLD  = 4'd2,
    PH_B_LOW   = 4'd3,
    PH_B_HIGH  = 4'd4,
    PH_A_LOW   = 4'd5,
    PH_A_HIGH  = 4'd6,
    PH_RS_LOW  = 4'd7,
    PH_R_LOW   = 4'd8,
    PH_R_HIGH  = 4'd9,
    PH_N_LOW   = 4'd10,
    PH_N_HIGH  = 4'd11,
    PH_P_LOW   = 4'd12,
    PH_P_HIGH  = 4'd13,
    PH_P_END   = 4'd14,
    PH_W_WAIT  = 4'd15
  } phase_e;

  // configuration register file contents
  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  bit_half_ticks;
    logic [7:0]  start_stop_ticks;
    logic [7:0]  ack_timeout_polls;
    logic [15:0] write_wait_ticks;
  } cfg_t;

  // one result of a tick
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       status;
  } res_t;

endpackage

### hdl/i2cm_core.sv
// bus sequencer state and its single-tick next-state logic
`include "i2c_eeprom_byte_access_master_unit_defines.svh"

module i2cm_core import i2cm_pkg::*; #(
  parameter int unsigned WAIT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] action_i,
  input  logic [7:0] word_address_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_in_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e               phase_q, phase_d;
  logic [7:0]           shift_q, shift_d;
  logic [3:0]           bit_cnt_q, bit_cnt_d;
  logic [2:0]           byte_idx_q, byte_idx_d;
  logic [WAIT_BITS-1:0] tick_q, tick_d;
  logic [7:0]           ack_wait_q, ack_wait_d;
  logic [7:0]           held_addr_q, held_addr_d;
  logic [7:0]           held_data_q, held_data_d;
  logic                 is_read_q, is_read_d;
  logic [7:0]           read_q, read_d;
  logic                 status_q, status_d;

  logic [WAIT_BITS-1:0] tick_inc;
  logic [WAIT_BITS-1:0] dur;
  logic [WAIT_BITS-1:0] dur_raw;
  logic [WAIT_BITS-1:0] wait_dur;
  logic [WAIT_BITS-1:0] bit_dur;
  logic [WAIT_BITS-1:0] ss_dur;
  logic [31:0]          wait_ext;
  logic [31:0]          bit_ext;
  logic [31:0]          ss_ext;
  logic [2:0]           idx_n;
  logic [3:0]           cnt_n;
  logic                 done;

  // byte to send for a given position in the transaction
  function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic rd,
                                          input logic [6:0] dev, input logic [7:0] addr,
                                          input logic [7:0] data);
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = {dev, 1'b0};
    end else if (idx == 3'd1) begin
      b = addr;
    end else if (rd) begin
      b = {dev, 1'b1};
    end else begin
      b = data;
    end
    return b;
  endfunction

  // phase durations at tick counter width
  assign wait_ext = {16'd0, cfg_i.write_wait_ticks};
  assign bit_ext  = {24'd0, cfg_i.bit_half_ticks};
  assign ss_ext   = {24'd0, cfg_i.start_stop_ticks};
  assign wait_dur = wait_ext[WAIT_BITS-1:0];
  assign bit_dur  = bit_ext[WAIT_BITS-1:0];
  assign ss_dur   = ss_ext[WAIT_BITS-1:0];

  always_comb begin
    unique case (phase_q)
      PH_S_SETUP, PH_S_HOLD, PH_P_LOW, PH_P_HIGH, PH_P_END: dur_raw = ss_dur;
      PH_W_WAIT: dur_raw = wait_dur;
      default:   dur_raw = bit_dur;
    endcase
    // a zero duration lasts one tick
    dur = (dur_raw == '0) ? {{(WAIT_BITS-1){1'b0}}, 1'b1} : dur_raw;
  end

  assign tick_inc = tick_q + {{(WAIT_BITS-1){1'b0}}, 1'b1};
  assign idx_n    = byte_idx_q + 3'd1;

  // next state and result of one tick
  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    bit_cnt_d   = bit_cnt_q;
    byte_idx_d  = byte_idx_q;
    tick_d      = tick_q;
    ack_wait_d  = ack_wait_q;
    held_addr_d = held_addr_q;
    held_data_d = held_data_q;
    is_read_d   = is_read_q;
    read_d      = read_q;
    status_d    = status_q;
    done        = 1'b0;
    cnt_n       = bit_cnt_q + 4'd1;

    if (phase_q == PH_IDLE) begin
      // command pickup
      if (action_i == ACT_WRITE || action_i == ACT_READ) begin
        held_addr_d = word_address_i;
        held_data_d = write_data_i;
        is_read_d   = (action_i == ACT_READ);
        status_d    = 1'b0;
        byte_idx_d  = 3'd0;
        phase_d     = PH_S_SETUP;
        tick_d      = '0;
      end
    end else if (phase_q == PH_A_HIGH) begin
      // acknowledge poll while the clock is high
      if (!sda_in_i) begin
        byte_idx_d = idx_n;
        tick_d     = '0;
        if (!is_read_q) begin
          if (idx_n < 3'd3) begin
            shift_d   = byte_for(idx_n, is_read_q, cfg_i.device_address,
                                 held_addr_q, held_data_q);
            bit_cnt_d = 4'd0;
            phase_d   = PH_B_LOW;
          end else begin
            phase_d = PH_P_LOW;
          end
        end else if (idx_n == 3'd2) begin
          phase_d = PH_RS_LOW;
        end else if (idx_n < 3'd2) begin
          shift_d   = byte_for(idx_n, is_read_q, cfg_i.device_address,
                               held_addr_q, held_data_q);
          bit_cnt_d = 4'd0;
          phase_d   = PH_B_LOW;
        end else begin
          shift_d   = 8'd0;
          bit_cnt_d = 4'd0;
          phase_d   = PH_R_LOW;
        end
      end else if (ack_wait_q >= cfg_i.ack_timeout_polls) begin
        status_d = 1'b1;
        phase_d  = PH_P_LOW;
        tick_d   = '0;
      end else begin
        ack_wait_d = ack_wait_q + 8'd1;
      end
    end else begin
      // timed phases
      tick_d = tick_inc;
      if (tick_inc >= dur) begin
        tick_d = '0;
        unique case (phase_q)
          PH_S_SETUP: phase_d = PH_S_HOLD;
          PH_S_HOLD: begin
            shift_d   = byte_for(byte_idx_q, is_read_q, cfg_i.device_address,
                                 held_addr_q, held_data_q);
            bit_cnt_d = 4'd0;
            phase_d   = PH_B_LOW;
          end
          PH_B_LOW: phase_d = PH_B_HIGH;
          PH_B_HIGH: begin
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = cnt_n;
            if (cnt_n >= BYTE_BITS) begin
              ack_wait_d = 8'd0;
              phase_d    = PH_A_LOW;
            end else begin
              phase_d = PH_B_LOW;
            end
          end
          PH_A_LOW:  phase_d = PH_A_HIGH;
          PH_RS_LOW: phase_d = PH_S_SETUP;
          PH_R_LOW:  phase_d = PH_R_HIGH;
          PH_R_HIGH: begin
            shift_d   = {shift_q[6:0], sda_in_i};
            bit_cnt_d = cnt_n;
            phase_d   = (cnt_n >= BYTE_BITS) ? PH_N_LOW : PH_R_LOW;
          end
          PH_N_LOW: phase_d = PH_N_HIGH;
          PH_N_HIGH: begin
            read_d  = shift_q;
            phase_d = PH_P_LOW;
          end
          PH_P_LOW:  phase_d = PH_P_HIGH;
          PH_P_HIGH: phase_d = PH_P_END;
          PH_P_END: begin
            if (!is_read_q && !status_q && wait_dur != '0) begin
              phase_d = PH_W_WAIT;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end

    // pin drive follows the updated phase
    res_o.scl    = 1'b1;
    res_o.sda    = 1'b1;
    res_o.sda_en = 1'b1;
    unique case (phase_d)
      PH_S_HOLD: res_o.sda = 1'b0;
      PH_B_LOW: begin
        res_o.scl = 1'b0;
        res_o.sda = shift_d[7];
      end
      PH_B_HIGH: res_o.sda = shift_d[7];
      PH_A_LOW, PH_R_LOW: begin
        res_o.scl    = 1'b0;
        res_o.sda_en = 1'b0;
      end
      PH_A_HIGH, PH_R_HIGH: res_o.sda_en = 1'b0;
      PH_RS_LOW, PH_N_LOW: res_o.scl = 1'b0;
      PH_P_LOW: begin
        res_o.scl = 1'b0;
        res_o.sda = 1'b0;
      end
      PH_P_HIGH: res_o.sda = 1'b0;
      default: ;
    endcase
    res_o.busy      = (phase_d != PH_IDLE);
    res_o.done      = done;
    res_o.read_data = read_d;
    res_o.status    = status_d;
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      shift_q     <= 8'd0;
      bit_cnt_q   <= 4'd0;
      byte_idx_q  <= 3'd0;
      tick_q      <= '0;
      ack_wait_q  <= 8'd0;
      held_addr_q <= 8'd0;
      held_data_q <= 8'd0;
      is_read_q   <= 1'b0;
      read_q      <= 8'd0;
      status_q    <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_idx_q  <= byte_idx_d;
      tick_q      <= tick_d;
      ack_wait_q  <= ack_wait_d;
      held_addr_q <= held_addr_d;
      held_data_q <= held_data_d;
      is_read_q   <= is_read_d;
      read_q      <= read_d;
      status_q    <= status_d;
    end
  end

  // sequencer checks
  `I2CM_ASSERT(a_done_to_idle, clk_i, rst_ni, (step_i && res_o.done) |=> (phase_q == PH_IDLE), "done without return to idle")
  `I2CM_ASSERT(a_bit_cnt_range, clk_i, rst_ni, (bit_cnt_q <= BYTE_BITS), "bit count beyond a byte")
  `I2CM_ASSERT(a_byte_idx_range, clk_i, rst_ni, (byte_idx_q <= 3'd3), "byte index beyond the last byte")

endmodule

### hdl/i2c_eeprom_byte_access_master_unit.sv
// top level of the two-wire eeprom bus master: config registers and result register
// Each accepted input is one bus tick and yields exactly one result in the next cycle, and a
// tick can be accepted in every cycle unless a stalled result holds it (one item per cycle
// without stalls), through the single registered pass of the sequencer next-state logic and
// a result register that lets a new tick in while the previous result is taken.
// A byte write runs start, device address, word address, data, stop and then
// write_wait_ticks idle ticks; a random read runs start, device address, word address,
// repeated start, device read address, eight data bits, no acknowledge and stop. Bit
// halves last bit_half_ticks ticks, start and stop steps start_stop_ticks ticks. Commands
// are ignored while busy; a missing acknowledge ends the transfer with a stop and status 1.
// The user writes configuration only while no transaction is running; no check enforces it.
`include "i2c_eeprom_byte_access_master_unit_defines.svh"

module i2c_eeprom_byte_access_master_unit import i2cm_pkg::*; #(
  parameter int unsigned WAIT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  word_address_i,
  input  logic [7:0]  write_data_i,
  input  logic        sda_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        sda_drive_enable_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        status_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic in_accept;

  // a tick is taken whenever the result register is free or being emptied
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= RST_DEVICE_ADDRESS;
      cfg_q.bit_half_ticks    <= RST_BIT_HALF_TICKS;
      cfg_q.start_stop_ticks  <= RST_START_STOP_TICKS;
      cfg_q.ack_timeout_polls <= RST_ACK_TIMEOUT_POLLS;
      cfg_q.write_wait_ticks  <= RST_WRITE_WAIT_TICKS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data_i[6:0];
        CFG_BIT_HALF_TICKS:    cfg_q.bit_half_ticks    <= cfg_data_i[7:0];
        CFG_START_STOP_TICKS:  cfg_q.start_stop_ticks  <= cfg_data_i[7:0];
        CFG_ACK_TIMEOUT_POLLS: cfg_q.ack_timeout_polls <= cfg_data_i[7:0];
        CFG_WRITE_WAIT_TICKS:  cfg_q.write_wait_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bus sequencer
  i2cm_core #(
    .WAIT_BITS(WAIT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_accept),
    .action_i       (action_i),
    .word_address_i (word_address_i),
    .write_data_i   (write_data_i),
    .sda_in_i       (sda_in_i),
    .cfg_i          (cfg_q),
    .res_o          (res_d)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign scl_out_o          = res_q.scl;
  assign sda_out_o          = res_q.sda;
  assign sda_drive_enable_o = res_q.sda_en;
  assign busy_res_o         = res_q.busy;
  assign done_res_o         = res_q.done;
  assign read_data_o        = res_q.read_data;
  assign status_o           = res_q.status;

  // result register checks
  `I2CM_ASSERT(a_accept_gives_result, clk_i, rst_ni, in_accept |=> out_valid_o, "accepted tick gave no result")
  `I2CM_ASSERT(a_empty_never_stalls, clk_i, rst_ni, !out_valid_o |-> !in_stall_o, "stall with empty result register")
  `I2CM_ASSERT(a_cfg_dev_write, clk_i, rst_ni, (cfg_valid_i && cfg_index_i == CFG_DEVICE_ADDRESS) |=> (cfg_q.device_address == $past(cfg_data_i[6:0])), "device address write lost")

endmodule

### test/i2c_eeprom_byte_access_master_unit_tb.sv
// self-checking testbench for the two-wire eeprom bus master, with its own bus predictor
`timescale 1ns / 1ps

module i2c_eeprom_byte_access_master_unit_tb;
  import i2cm_pkg::*;

  // tick-only action codes and other testbench codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
  localparam int NO_FAIL = 3;
  // directed rows from this one on run with short timing and a short ack timeout
  localparam int         FAST_ROW   = 3;
  localparam logic [7:0] FAST_POLLS = 8'd8;

  // one bus command with the behavior of the emulated eeprom during it
  typedef struct {
    logic [1:0] act;
    logic [7:0] wa;
    logic [7:0] wd;
    int         ack_after;
    int         fail_at;
    logic [7:0] reply;
    bit         noisy;
    bit         chk;
    res_t       want;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [7:0]  word_address_i;
  logic [7:0]  write_data_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        sda_drive_enable_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_data_o;
  logic        status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  i2c_eeprom_byte_access_master_unit u_top (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  cfg_t       model_cfg;
  phase_e     bus_ph;
  logic [7:0] sh_reg;
  logic [3:0] bit_cnt;
  logic [2:0] byte_idx;
  logic [15:0] tick_cnt;
  logic [7:0] poll_cnt;
  logic [7:0] hold_addr;
  logic [7:0] hold_data;
  logic       rd_cmd;
  logic [7:0] last_read;
  logic       last_status;

  res_t     expected_bus_q[$];
  res_t     last_res;
  cmd_row_t cur_cmd;
  cmd_row_t directed_plan [14];

  int mismatches = 0;
  int results_seen = 0;
  int ticks_accepted = 0;
  int writes_done = 0;
  int reads_done = 0;
  int ack_timeouts = 0;
  int settings_used = 1;
  int stall_left = 0;
  int calm_left = 0;
  bit calm = 1'b0;

  function automatic void enter_phase(input phase_e p);
    bus_ph   = p;
    tick_cnt = '0;
  endfunction

  // load the next byte to send and start its first clock-low half
  function automatic void load_byte();
    case (byte_idx)
      3'd0:    sh_reg = {model_cfg.device_address, 1'b0};
      3'd1:    sh_reg = hold_addr;
      default: sh_reg = rd_cmd ? {model_cfg.device_address, 1'b1} : hold_data;
    endcase
    bit_cnt = '0;
    enter_phase(PH_B_LOW);
  endfunction

  // advance the bus sequencer by one tick and return the pin and status result
  function automatic res_t predict_tick(input logic [1:0] act, input logic [7:0] wa,
                                        input logic [7:0] wd, input logic sda);
    res_t        r;
    logic        fin;
    logic [15:0] len;
    fin = 1'b0;
    if (bus_ph == PH_IDLE) begin
      if (act == ACT_WRITE || act == ACT_READ) begin
        hold_addr   = wa;
        hold_data   = wd;
        rd_cmd      = (act == ACT_READ);
        last_status = 1'b0;
        byte_idx    = '0;
        enter_phase(PH_S_SETUP);
      end
    end else if (bus_ph == PH_A_HIGH) begin
      // acknowledge poll: low is an ack, high counts toward the timeout
      if (!sda) begin
        byte_idx = byte_idx + 3'd1;
        if (!rd_cmd) begin
          if (byte_idx < 3'd3) load_byte();
          else enter_phase(PH_P_LOW);
        end else if (byte_idx == 3'd2) begin
          enter_phase(PH_RS_LOW);
        end else if (byte_idx < 3'd2) begin
          load_byte();
        end else begin
          sh_reg  = '0;
          bit_cnt = '0;
          enter_phase(PH_R_LOW);
        end
      end else if (poll_cnt >= model_cfg.ack_timeout_polls) begin
        last_status = 1'b1;
        enter_phase(PH_P_LOW);
      end else begin
        poll_cnt = poll_cnt + 8'd1;
      end
    end else begin
      // timed phases
      case (bus_ph)
        PH_S_SETUP, PH_S_HOLD, PH_P_LOW, PH_P_HIGH, PH_P_END:
          len = 16'(model_cfg.start_stop_ticks);
        PH_W_WAIT: len = model_cfg.write_wait_ticks;
        default:   len = 16'(model_cfg.bit_half_ticks);
      endcase
      if (len == '0) len = 16'd1;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= len) begin
        case (bus_ph)
          PH_S_SETUP: enter_phase(PH_S_HOLD);
          PH_S_HOLD:  load_byte();
          PH_B_LOW:   enter_phase(PH_B_HIGH);
          PH_B_HIGH: begin
            sh_reg  = sh_reg << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BYTE_BITS) begin
              poll_cnt = '0;
              enter_phase(PH_A_LOW);
            end else begin
              enter_phase(PH_B_LOW);
            end
          end
          PH_A_LOW:  enter_phase(PH_A_HIGH);
          PH_RS_LOW: enter_phase(PH_S_SETUP);
          PH_R_LOW:  enter_phase(PH_R_HIGH);
          PH_R_HIGH: begin
            sh_reg  = {sh_reg[6:0], sda};
            bit_cnt = bit_cnt + 4'd1;
            enter_phase(bit_cnt >= BYTE_BITS ? PH_N_LOW : PH_R_LOW);
          end
          PH_N_LOW: enter_phase(PH_N_HIGH);
          PH_N_HIGH: begin
            last_read = sh_reg;
            enter_phase(PH_P_LOW);
          end
          PH_P_LOW:  enter_phase(PH_P_HIGH);
          PH_P_HIGH: enter_phase(PH_P_END);
          PH_P_END: begin
            if (!rd_cmd && !last_status && model_cfg.write_wait_ticks != '0) begin
              enter_phase(PH_W_WAIT);
            end else begin
              enter_phase(PH_IDLE);
              fin = 1'b1;
            end
          end
          default: begin
            enter_phase(PH_IDLE);
            fin = 1'b1;
          end
        endcase
      end
    end

    // pin drive for the phase after this tick
    r.scl    = 1'b1;
    r.sda    = 1'b1;
    r.sda_en = 1'b1;
    case (bus_ph)
      PH_S_HOLD: r.sda = 1'b0;
      PH_B_LOW: begin
        r.scl = 1'b0;
        r.sda = sh_reg[7];
      end
      PH_B_HIGH: r.sda = sh_reg[7];
      PH_A_LOW, PH_R_LOW: begin
        r.scl    = 1'b0;
        r.sda_en = 1'b0;
      end
      PH_A_HIGH, PH_R_HIGH: r.sda_en = 1'b0;
      PH_RS_LOW, PH_N_LOW: r.scl = 1'b0;
      PH_P_LOW: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      PH_P_HIGH: r.sda = 1'b0;
      default: ;
    endcase
    r.busy      = (bus_ph != PH_IDLE);
    r.done      = fin;
    r.read_data = last_read;
    r.status    = last_status;
    return r;
  endfunction

  function automatic res_t finish_result(input logic [7:0] rd, input logic st);
    return {1'b1, 1'b1, 1'b1, 1'b0, 1'b1, rd, st};
  endfunction

  function automatic void check_field(input string where, input string field,
                                      input logic [7:0] expv, input logic [7:0] gotv);
    if (gotv !== expv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %s, %s: expected %h, got %h", where, field, expv, gotv);
    end
  endfunction

  function automatic void check_result(input string where, input res_t want, input res_t got);
    check_field(where, "scl_out", 8'(want.scl), 8'(got.scl));
    check_field(where, "sda_out", 8'(want.sda), 8'(got.sda));
    check_field(where, "sda_drive_enable", 8'(want.sda_en), 8'(got.sda_en));
    check_field(where, "busy_res", 8'(want.busy), 8'(got.busy));
    check_field(where, "done_res", 8'(want.done), 8'(got.done));
    check_field(where, "read_data", want.read_data, got.read_data);
    check_field(where, "status", 8'(want.status), 8'(got.status));
  endfunction

  // level the emulated eeprom puts on the data line for the coming tick
  function automatic logic bus_level();
    if (cur_cmd.noisy) return 1'($urandom_range(0, 1));
    case (bus_ph)
      PH_A_HIGH: begin
        if (int'(byte_idx) == cur_cmd.fail_at) return 1'b1;
        return (int'(poll_cnt) >= cur_cmd.ack_after) ? 1'b0 : 1'b1;
      end
      PH_R_HIGH: return cur_cmd.reply[3'd7 - bit_cnt[2:0]];
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // stretches without any idling on either side
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    int n;
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      n = pick_gap();
      out_stall_i <= (n != 0);
      if (n != 0) stall_left = n - 1;
    end
  end

  // check each result transfer, apply register writes, predict each tick transfer
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {scl_out_o, sda_out_o, sda_drive_enable_o, busy_res_o, done_res_o,
               read_data_o, status_o};
        last_res = got;
        results_seen++;
        if (expected_bus_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          check_result($sformatf("result %0d", results_seen), expected_bus_q.pop_front(), got);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEVICE_ADDRESS:    model_cfg.device_address    = cfg_data_i[6:0];
          CFG_BIT_HALF_TICKS:    model_cfg.bit_half_ticks    = cfg_data_i[7:0];
          CFG_START_STOP_TICKS:  model_cfg.start_stop_ticks  = cfg_data_i[7:0];
          CFG_ACK_TIMEOUT_POLLS: model_cfg.ack_timeout_polls = cfg_data_i[7:0];
          CFG_WRITE_WAIT_TICKS:  model_cfg.write_wait_ticks  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        want = predict_tick(action_i, word_address_i, write_data_i, sda_in_i);
        expected_bus_q.push_back(want);
        ticks_accepted++;
        if (want.done) begin
          if (want.status) ack_timeouts++;
          else if (rd_cmd) reads_done++;
          else writes_done++;
        end
      end
    end
  end

  // one tick transfer; called and returns at a falling edge
  task automatic send_item(input logic [1:0] act, input logic [7:0] wa, input logic [7:0] wd);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    word_address_i <= wa;
    write_data_i   <= wd;
    sda_in_i       <= bus_level();
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_bus_q.size() != 0) @(negedge clk_i);
  endtask

  // issue one command, then keep ticking with random busy traffic until idle
  task automatic run_command(input cmd_row_t c);
    cur_cmd = c;
    send_item(c.act, c.wa, c.wd);
    if ($urandom_range(0, 11) == 0) wait_drain();
    while (bus_ph != PH_IDLE) send_item(2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // write all registers plus one unused index; junk in the unused upper data bits
  task automatic program_regs(input logic [6:0] dev, input logic [7:0] half,
                              input logic [7:0] ss, input logic [7:0] polls,
                              input logic [15:0] wwait);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    idx = '{CFG_UNUSED_IDX, CFG_DEVICE_ADDRESS, CFG_BIT_HALF_TICKS, CFG_START_STOP_TICKS,
            CFG_ACK_TIMEOUT_POLLS, CFG_WRITE_WAIT_TICKS};
    val = '{16'($urandom), {9'($urandom), dev}, {8'($urandom), half}, {8'($urandom), ss},
            {8'($urandom), polls}, wwait};
    wait_drain();
    repeat (2) @(negedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed commands with random content, some noise and broken acks
  task automatic random_phase(input int budget);
    cmd_row_t c;
    int       start;
    int       r;
    start = ticks_accepted;
    while (ticks_accepted - start < budget) begin
      r = $urandom_range(0, 9);
      c.act       = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
      c.wa        = 8'($urandom);
      c.wd        = 8'($urandom);
      c.reply     = 8'($urandom);
      c.ack_after = ($urandom_range(0, 9) < 7) ? 0 :
                    $urandom_range(0, int'(model_cfg.ack_timeout_polls) + 1);
      c.fail_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : NO_FAIL;
      c.noisy     = (r == 7);
      c.chk       = 1'b0;
      c.want      = '0;
      if (r >= 8) c.act = (r == 8) ? ACT_TICK : ACT_SPARE;
      run_command(c);
    end
  endtask

  // stimulus
  initial begin
    cmd_row_t c;
    in_valid_i     = 1'b0;
    action_i       = ACT_TICK;
    word_address_i = '0;
    write_data_i   = '0;
    sda_in_i       = 1'b1;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_DEVICE_ADDRESS;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;

    model_cfg   = {RST_DEVICE_ADDRESS, RST_BIT_HALF_TICKS, RST_START_STOP_TICKS,
                   RST_ACK_TIMEOUT_POLLS, RST_WRITE_WAIT_TICKS};
    bus_ph      = PH_IDLE;
    sh_reg      = '0;
    bit_cnt     = '0;
    byte_idx    = '0;
    tick_cnt    = '0;
    poll_cnt    = '0;
    hold_addr   = '0;
    hold_data   = '0;
    rd_cmd      = 1'b0;
    last_read   = '0;
    last_status = 1'b0;
    last_res    = '0;

    // directed commands: idle bus, spare action and one read at reset settings, then
    // short timing for field extremes, late and last-moment acks, and a missing ack
    // at each byte position
    directed_plan = '{
      '{ACT_TICK,  8'h00, 8'h00,   0, NO_FAIL, 8'h00, 1'b0, 1'b1,
        {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{ACT_SPARE, 8'hFF, 8'hFF,   0, NO_FAIL, 8'h00, 1'b0, 1'b1,
        {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{ACT_READ,  8'h00, 8'h00,   0, NO_FAIL, 8'hFF, 1'b0, 1'b1, finish_result(8'hFF, 1'b0)},
      '{ACT_WRITE, 8'h00, 8'hFF,   0, NO_FAIL, 8'h00, 1'b0, 1'b1, finish_result(8'hFF, 1'b0)},
      '{ACT_WRITE, 8'hFF, 8'h00,   2, NO_FAIL, 8'h00, 1'b0, 1'b1, finish_result(8'hFF, 1'b0)},
      '{ACT_READ,  8'hFF, 8'hFF,   1, NO_FAIL, 8'h00, 1'b0, 1'b1, finish_result(8'h00, 1'b0)},
      '{ACT_READ,  8'hA5, 8'h5A,   0, NO_FAIL, 8'hA5, 1'b0, 1'b1, finish_result(8'hA5, 1'b0)},
      '{ACT_WRITE, 8'h12, 8'h34,   0, 2,       8'h00, 1'b0, 1'b1, finish_result(8'hA5, 1'b1)},
      '{ACT_READ,  8'h56, 8'h78,   0, 2,       8'h00, 1'b0, 1'b1, finish_result(8'hA5, 1'b1)},
      '{ACT_READ,  8'h9A, 8'hBC,   0, 0,       8'h00, 1'b0, 1'b1, finish_result(8'hA5, 1'b1)},
      '{ACT_WRITE, 8'h33, 8'hCC,   0, 1,       8'h00, 1'b0, 1'b1, finish_result(8'hA5, 1'b1)},
      '{ACT_WRITE, 8'h81, 8'h7E, int'(FAST_POLLS), NO_FAIL, 8'h00, 1'b0, 1'b1,
        finish_result(8'hA5, 1'b0)},
      '{ACT_READ,  8'h42, 8'h24, int'(FAST_POLLS) + 1, NO_FAIL, 8'h00, 1'b0, 1'b1,
        finish_result(8'hA5, 1'b1)},
      '{ACT_WRITE, 8'h7E, 8'h81,   0, NO_FAIL, 8'h00, 1'b1, 1'b0, '0}
    };

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[i]) begin
      if (i == FAST_ROW) program_regs(RST_DEVICE_ADDRESS, 8'd1, 8'd1, FAST_POLLS, 16'd3);
      run_command(directed_plan[i]);
      wait_drain();
      if (directed_plan[i].chk)
        check_result($sformatf("directed command %0d", i), directed_plan[i].want, last_res);
    end

    // random traffic over several timing settings, zero durations among them
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: program_regs(7'($urandom), 8'd1, 8'd1, 8'd3, 16'd2);
        1: program_regs(7'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        2: program_regs(7'd127, 8'd2, 8'd1, 8'($urandom_range(1, 8)),
                        16'($urandom_range(1, 20)));
        default: program_regs(7'($urandom), 8'($urandom_range(1, 3)),
                              8'($urandom_range(1, 3)), 8'($urandom_range(0, 6)),
                              16'($urandom_range(0, 30)));
      endcase
      random_phase(40);
    end

    // longest acknowledge timeout: a read losing its device address ack
    program_regs(7'd127, 8'd1, 8'd1, 8'd255, 16'd1);
    c = '{ACT_READ, 8'($urandom), 8'($urandom), 0, 0, 8'h00, 1'b0, 1'b0, '0};
    run_command(c);

    wait_drain();
    repeat (8) @(negedge clk_i);

    $display("covered %0d ticks and %0d checked results: %0d writes, %0d reads, %0d ack timeouts",
             ticks_accepted, results_seen, writes_done, reads_done, ack_timeouts);
    $display("used %0d register settings, zero durations up to the longest ack timeout; %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("run did not finish in time, %0d results still expected", expected_bus_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
